[hdl/chunked_body_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Chunked body decoder assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_BODY_DECODER_DEFINES_SVH
`define CHUNKED_BODY_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("chunked body decoder: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("chunked body decoder: assertion failed");
`else
`define CBD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/cbd_pkg.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Phase encoding, character codes and byte classification helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	localparam int CBD_SIZE_BITS = 32;
	localparam int COUNT_BITS = 32;

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TAB = 8'd9;

	// Number of bytes that follow each chunk's data and are skipped.
	localparam logic [1:0] SKIP_BYTES = 2'd2;

	// hex_value returns this code for a byte that is not a hex digit.
	localparam logic [4:0] HEX_NONE = 5'd16;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_SKIP = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] v;
		begin
			v = 8'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				v = c - 8'h30;
			end else if (c >= 8'h61 && c <= 8'h66) begin
				v = c - 8'h57;
			end else if (c >= 8'h41 && c <= 8'h46) begin
				v = c - 8'h37;
			end else begin
				v = {3'd0, HEX_NONE};
			end
			return v[4:0];
		end
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		begin
			return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		end
	endfunction

endpackage

`default_nettype wire

[hdl/cbd_stream_if.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder channels
// Valid/ready interfaces for the raw body bytes and the decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbd_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, body_byte, first_byte, last_byte, input ready);
	modport sink (input valid, body_byte, first_byte, last_byte, output ready);
endinterface

interface cbd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        bad_size_char;
	logic        body_done;
	logic [31:0] payload_total;
	logic        last_result;

	modport source (output valid, payload_byte, payload_valid, bad_size_char, body_done,
		payload_total, last_result, input ready);
	modport sink (input valid, payload_byte, payload_valid, bad_size_char, body_done,
		payload_total, last_result, output ready);
endinterface

`default_nettype wire

[hdl/chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// Chunked body decoder
// Strips size lines and trailers of a chunked HTTP body, at most a byte a cycle.
// ----------------------------------------------------------------------------
// Usage:
// Raw body bytes enter on the body channel; first_byte clears the decoder
// before its byte is handled, last_byte is only carried through.
// Every request on the body channel produces exactly one request on the
// result channel, in order. payload_valid marks bytes that belong to chunk
// data; payload_byte is zero otherwise. bad_size_char flags a size-line byte
// that is neither a hex digit nor whitespace, body_done is high from the end
// of the zero-size line on, and payload_total is the running payload count.
// An accepted byte is held in the input register; then the result register,
// where the phase state and the chunk counter are updated, loads its result
// and presents it.
// Throughput is one byte per cycle while the result channel does not stall;
// the registered state update of one byte feeds the next byte.
// After reset both registers are empty and the decoder waits for a size line.
// When the result receiver stalls, the result register holds its request and
// the input register fills; body.ready then drops until the stall clears.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chunked_body_decoder_defines.svh"

module chunked_body_decoder #(
	parameter int SIZE_BITS = cbd_pkg::CBD_SIZE_BITS
) (
	input  wire          clk,
	input  wire          arst_n,
	cbd_body_if.sink     body,
	cbd_result_if.source result
);
	import cbd_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;

	// Decoder state.
	phase_t                 phase_q;
	logic                   cr_pending_q;
	logic [SIZE_BITS-1:0]   remaining_q;
	logic [1:0]             skip_left_q;
	logic [COUNT_BITS-1:0]  payload_count_q;

	// Result register.
	logic                  out_valid_q;
	logic [7:0]            payload_byte_q;
	logic                  payload_valid_q;
	logic                  bad_size_char_q;
	logic                  body_done_q;
	logic [COUNT_BITS-1:0] payload_total_q;
	logic                  last_result_q;

	logic out_free;
	logic advance;

	// State as seen by the byte in the input register, after a first_byte clear.
	phase_t                base_phase;
	logic                  base_cr;
	logic [SIZE_BITS-1:0]  base_rem;
	logic [1:0]            base_skip;
	logic [COUNT_BITS-1:0] base_count;

	logic [4:0]            hex_d;
	logic                  line_end;
	logic [SIZE_BITS-1:0]  rem_dec;
	logic [1:0]            skip_dec;

	phase_t                phase_d;
	logic                  cr_d;
	logic [SIZE_BITS-1:0]  rem_d;
	logic [1:0]            skip_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  pvalid_d;
	logic                  bad_d;

	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign body.ready = !valid_s1 || out_free;

	always_comb begin
		if (first_s1) begin
			base_phase = PH_SIZE;
			base_cr    = 1'b0;
			base_rem   = '0;
			base_skip  = '0;
			base_count = '0;
		end else begin
			base_phase = phase_q;
			base_cr    = cr_pending_q;
			base_rem   = remaining_q;
			base_skip  = skip_left_q;
			base_count = payload_count_q;
		end
	end

	assign hex_d    = hex_value(byte_s1);
	assign line_end = base_cr && (byte_s1 == CH_LF);
	assign rem_dec  = base_rem - {{(SIZE_BITS-1){1'b0}}, 1'b1};
	assign skip_dec = base_skip - 2'd1;

	// Next phase.
	always_comb begin
		phase_d = base_phase;
		unique case (base_phase)
			PH_SIZE: begin
				if (line_end) begin
					phase_d = (base_rem == '0) ? PH_DONE : PH_DATA;
				end
			end
			PH_DATA: begin
				if (rem_dec == '0) begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (skip_dec == 2'd0) begin
					phase_d = PH_SIZE;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_SIZE;
			end
		endcase
	end

	// Datapath and flags.
	always_comb begin
		cr_d     = base_cr;
		rem_d    = base_rem;
		skip_d   = base_skip;
		count_d  = base_count;
		pvalid_d = 1'b0;
		bad_d    = 1'b0;
		unique case (base_phase)
			PH_SIZE: begin
				if (line_end) begin
					cr_d = 1'b0;
				end else begin
					cr_d = (byte_s1 == CH_CR);
					if (hex_d != HEX_NONE) begin
						// Shift in one hex digit, dropping the top nibble.
						rem_d = {base_rem[SIZE_BITS-5:0], hex_d[3:0]};
					end else if (!is_blank(byte_s1)) begin
						bad_d = 1'b1;
					end
				end
			end
			PH_DATA: begin
				pvalid_d = 1'b1;
				count_d  = base_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
				rem_d    = rem_dec;
				if (rem_dec == '0) begin
					skip_d = SKIP_BYTES;
				end
			end
			PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 2'd0) begin
					rem_d = '0;
					cr_d  = 1'b0;
				end
			end
			PH_DONE: begin
				cr_d = base_cr;
			end
			default: begin
				cr_d = base_cr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (body.ready) begin
			valid_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			byte_s1  <= body.body_byte;
			first_s1 <= body.first_byte;
			last_s1  <= body.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_SIZE;
			cr_pending_q    <= 1'b0;
			remaining_q     <= '0;
			skip_left_q     <= '0;
			payload_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				phase_q         <= phase_d;
				cr_pending_q    <= cr_d;
				remaining_q     <= rem_d;
				skip_left_q     <= skip_d;
				payload_count_q <= count_d;
				out_valid_q     <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			payload_byte_q  <= pvalid_d ? byte_s1 : 8'd0;
			payload_valid_q <= pvalid_d;
			bad_size_char_q <= bad_d;
			body_done_q     <= (phase_d == PH_DONE);
			payload_total_q <= count_d;
			last_result_q   <= last_s1;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.payload_byte  = payload_byte_q;
	assign result.payload_valid = payload_valid_q;
	assign result.bad_size_char = bad_size_char_q;
	assign result.body_done     = body_done_q;
	assign result.payload_total = payload_total_q;
	assign result.last_result   = last_result_q;

	// Skipping the bytes after chunk data always has one or two bytes left to go.
	`CBD_ASSERT_SAME(a_skip_count, clk, arst_n, phase_q == PH_SKIP,
		skip_left_q == 2'd1 || skip_left_q == 2'd2)
	// Once decoding has ended, only a new body leaves the done phase.
	`CBD_ASSERT_NEXT(a_done_sticky, clk, arst_n, advance && !first_s1 && phase_q == PH_DONE,
		phase_q == PH_DONE)
	// Each data byte adds exactly one to the running count.
	`CBD_ASSERT_NEXT(a_count_step, clk, arst_n, advance && !first_s1 && phase_q == PH_DATA,
		payload_count_q == $past(payload_count_q) + 32'd1)
	// Bytes that are not payload leave a zero payload field.
	`CBD_ASSERT_SAME(a_payload_zero, clk, arst_n, out_valid_q && !payload_valid_q,
		payload_byte_q == 8'd0)

endmodule

`default_nettype wire
